// ===== src/stbs_pkg.sv =====
// Shared codes and field widths for the sorted table search block.
package stbs_pkg;

   // Request field widths
   localparam int POS_W = 4;
   localparam int KEY_W = 32;

   // Request command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // Classified operation codes passed from front to back
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_EMPTY  = 2'd2;

   // Entries in the front-to-back queue
   localparam int QUEUE_DEPTH = 2;

endpackage

// ===== src/sorted_table_binary_search.sv =====
// Top level of the sorted table binary search block.
//
// Holds TABLE_DEPTH signed 32-bit entries that the user keeps ascending.
// Request channel (req_*): cmd 0 writes req_value at req_position (a write
// past the table is dropped) and gives no response; cmd 1 searches for
// req_value over the inclusive index range req_range_low..req_range_high
// (high saturates to the last entry). Each search gives one response on
// rsp_*: found flag and index of the hit, index 0 when not found.
// Both channels use valid/stall; a transfer happens when valid && !stall.
// A two-entry request queue parts the front end from the back end.
// Flow: the back end does a write in its idle state. A search takes one
// issue step and then one probe per cycle, at most log2(TABLE_DEPTH) + 1
// probes, through the table RAM's registered read: the next entry is read
// while the current one is compared. An empty range needs no probe.
// The response register is loaded at the end of the last probe.
// While rsp_stall is high the response holds; a finished search waits in
// the back end, and the queue keeps accepting requests until it fills.
// Reset clears control state only; table contents are undefined until
// written and there is no clearing pass.
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [stbs_pkg::POS_W-1:0]        req_position,
   input  logic signed [stbs_pkg::KEY_W-1:0] req_value,
   input  logic [stbs_pkg::POS_W-1:0]        req_range_low,
   input  logic [stbs_pkg::POS_W-1:0]        req_range_high,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic [stbs_pkg::POS_W-1:0]        rsp_found_position
);
   import stbs_pkg::*;

   // Index width of the table, and a span width that holds both the
   // request index fields and one past the last entry.
   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int SPAN_W = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;
   localparam int Q_W    = OP_W + KEY_W + 2 * SPAN_W;

   logic                    q_full, q_push, q_pop, q_not_empty;
   logic [OP_W-1:0]         f_op, b_op;
   logic signed [KEY_W-1:0] f_key, b_key;
   logic [SPAN_W-1:0]       f_lo, f_hi, b_lo, b_hi;
   logic [Q_W-1:0]          q_head;

   // Classify: write, search, or search over an empty range.
   stbs_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .SPAN_W      (SPAN_W)
   ) u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_value      (req_value),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_op           (f_op),
      .q_key          (f_key),
      .q_lo           (f_lo),
      .q_hi           (f_hi)
   );

   stbs_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_op, f_key, f_lo, f_hi}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_data (q_head)
   );

   assign {b_op, b_key, b_lo, b_hi} = q_head;

   // Table RAM, probe sequencer and response register.
   stbs_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .SPAN_W      (SPAN_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_not_empty),
      .q_pop              (q_pop),
      .q_op               (b_op),
      .q_key              (b_key),
      .q_lo               (b_lo),
      .q_hi               (b_hi),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_found_position (rsp_found_position)
   );

endmodule

// ===== src/stbs_ram.sv =====
// Generic simple dual-port RAM with registered read.
module stbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/stbs_front.sv =====
// Request front end: accepts requests and classifies them for the back end.
module stbs_front #(
   parameter int TABLE_DEPTH = 16,
   parameter int SPAN_W      = 5
) (
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_cmd,
   input  logic [stbs_pkg::POS_W-1:0]      req_position,
   input  logic signed [stbs_pkg::KEY_W-1:0] req_value,
   input  logic [stbs_pkg::POS_W-1:0]      req_range_low,
   input  logic [stbs_pkg::POS_W-1:0]      req_range_high,
   input  logic                            q_full,
   output logic                            q_push,
   output logic [stbs_pkg::OP_W-1:0]       q_op,
   output logic signed [stbs_pkg::KEY_W-1:0] q_key,
   output logic [SPAN_W-1:0]               q_lo,
   output logic [SPAN_W-1:0]               q_hi
);
   import stbs_pkg::*;

   localparam logic [SPAN_W-1:0] LAST  = SPAN_W'(TABLE_DEPTH - 1);
   localparam logic [SPAN_W-1:0] LIMIT = SPAN_W'(TABLE_DEPTH);

   logic [SPAN_W-1:0] pos_ext;
   logic [SPAN_W-1:0] lo_ext;
   logic [SPAN_W-1:0] hi_ext;
   logic [SPAN_W-1:0] hi_sat;
   logic              keep;

   assign pos_ext = SPAN_W'(req_position);
   assign lo_ext  = SPAN_W'(req_range_low);
   assign hi_ext  = SPAN_W'(req_range_high);
   assign hi_sat  = (hi_ext > LAST) ? LAST : hi_ext;

   always_comb begin
      keep = 1'b1;
      q_op = OP_WRITE;
      q_lo = pos_ext;            // write index rides in the low field
      q_hi = hi_sat;
      if (req_cmd == CMD_SEARCH) begin
         q_lo = lo_ext;
         q_op = (lo_ext > hi_sat) ? OP_EMPTY : OP_SEARCH;
      end else if (pos_ext >= LIMIT) begin
         keep = 1'b0;            // write past the table: dropped
      end
   end

   assign q_key     = req_value;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full && keep;

endmodule

// ===== src/stbs_queue.sv =====
// Small FIFO between the front and back ends.
module stbs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign head_data = data_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count above depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

endmodule

// ===== src/stbs_back.sv =====
// Back end: table writes and the probe sequencer for searches.
module stbs_back #(
   parameter int TABLE_DEPTH = 16,
   parameter int IDX_W       = 4,
   parameter int SPAN_W      = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   output logic                              q_pop,
   input  logic [stbs_pkg::OP_W-1:0]         q_op,
   input  logic signed [stbs_pkg::KEY_W-1:0] q_key,
   input  logic [SPAN_W-1:0]                 q_lo,
   input  logic [SPAN_W-1:0]                 q_hi,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic [stbs_pkg::POS_W-1:0]        rsp_found_position
);
   import stbs_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PROBE = 2'd1;
   localparam logic [1:0] ST_HOLD  = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic signed [KEY_W-1:0]  key_ff, key_in;
   logic [SPAN_W-1:0]        lo_ff, lo_in;
   logic [SPAN_W-1:0]        hi_ff, hi_in;
   logic [SPAN_W-1:0]        mid_ff, mid_in;
   logic                     res_found_ff, res_found_in;
   logic [POS_W-1:0]         res_pos_ff, res_pos_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     out_found_ff, out_found_in;
   logic [POS_W-1:0]         out_pos_ff, out_pos_in;

   logic                     ram_we;
   logic [KEY_W-1:0]         ram_rdata;
   logic [SPAN_W-1:0]        next_lo, next_hi;
   logic [SPAN_W:0]          mid_sum;
   logic [SPAN_W-1:0]        mid_new;
   logic                     out_free;
   logic                     fin_valid, fin_found;
   logic [POS_W-1:0]         fin_pos;
   logic                     cmp_eq, cmp_lt;

   stbs_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (q_lo[IDX_W-1:0]),
      .wdata (q_key),
      .raddr (mid_new[IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   assign out_free = !out_valid_ff || !rsp_stall;
   assign cmp_eq   = (key_ff == $signed(ram_rdata));
   assign cmp_lt   = (key_ff <  $signed(ram_rdata));
   assign mid_sum  = {1'b0, next_lo} + {1'b0, next_hi};
   assign mid_new  = mid_sum[SPAN_W:1];

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      out_found_in = out_found_ff;
      out_pos_in   = out_pos_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      next_lo      = q_lo;
      next_hi      = q_hi;
      fin_valid    = 1'b0;
      fin_found    = 1'b0;
      fin_pos      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_op)
                  OP_WRITE: begin
                     q_pop  = 1'b1;
                     ram_we = 1'b1;
                  end
                  OP_SEARCH: begin
                     q_pop    = 1'b1;
                     key_in   = q_key;
                     lo_in    = q_lo;
                     hi_in    = q_hi;
                     mid_in   = mid_new;
                     state_in = ST_PROBE;
                  end
                  OP_EMPTY: begin
                     if (out_free) begin
                        q_pop        = 1'b1;
                        out_valid_in = 1'b1;
                        out_found_in = 1'b0;
                        out_pos_in   = '0;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_PROBE: begin
            if (cmp_eq) begin
               fin_valid = 1'b1;
               fin_found = 1'b1;
               fin_pos   = mid_ff[POS_W-1:0];
            end else if (cmp_lt && mid_ff == '0) begin
               fin_valid = 1'b1;   // key below entry zero
            end else begin
               if (cmp_lt) begin
                  next_lo = lo_ff;
                  next_hi = mid_ff - 1'b1;
               end else begin
                  next_lo = mid_ff + 1'b1;
                  next_hi = hi_ff;
               end
               if (next_lo > next_hi) begin
                  fin_valid = 1'b1;
               end else begin
                  lo_in  = next_lo;
                  hi_in  = next_hi;
                  mid_in = mid_new;
               end
            end
            if (fin_valid) begin
               if (out_free) begin
                  out_valid_in = 1'b1;
                  out_found_in = fin_found;
                  out_pos_in   = fin_pos;
                  state_in     = ST_IDLE;
               end else begin
                  res_found_in = fin_found;
                  res_pos_in   = fin_pos;
                  state_in     = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_found_in = res_found_ff;
               out_pos_in   = res_pos_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      out_found_ff <= out_found_in;
      out_pos_ff   <= out_pos_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_found          = out_found_ff;
   assign rsp_found_position = out_pos_ff;

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_IDLE)
      else $error("table write outside idle");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE)
      else $error("queue pop while a search is running");

   a_mid_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PROBE |-> (mid_ff >= lo_ff && mid_ff <= hi_ff))
      else $error("probe index outside search range");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the sorted table binary search block.
`timescale 1ns / 100ps

module tb;
   import stbs_pkg::*;

   localparam int DEPTH          = 16;
   localparam int RANDOM_ITEMS   = 500;
   localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
   localparam int DRAIN_CYCLES   = 20;    // drain time after the last checked response
   localparam int HOLD_AFTER     = 40;    // requests accepted before the long stall
   localparam int HOLD_CYCLES    = 80;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   // Idle phases: who backs off how often
   localparam logic [1:0] PH_RSP_BUSY = 2'd0;  // sender 7%, receiver 46%
   localparam logic [1:0] PH_REQ_BUSY = 2'd1;  // sender 46%, receiver 7%
   localparam logic [1:0] PH_NO_IDLE  = 2'd2;

   typedef struct packed {
      logic [1:0]       phase;
      logic             cmd;
      logic [POS_W-1:0] position;
      logic [KEY_W-1:0] value;
      logic [POS_W-1:0] range_low;
      logic [POS_W-1:0] range_high;
   } table_request_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] found_position;
   } search_result_type;

   logic                    clock              = 1'b0;
   logic                    reset              = 1'b1;
   logic                    req_valid          = 1'b0;
   logic                    req_stall;
   logic                    req_cmd            = CMD_WRITE;
   logic [POS_W-1:0]        req_position       = '0;
   logic signed [KEY_W-1:0] req_value          = '0;
   logic [POS_W-1:0]        req_range_low      = '0;
   logic [POS_W-1:0]        req_range_high     = '0;
   logic                    rsp_valid;
   logic                    rsp_stall          = 1'b0;
   logic                    rsp_found;
   logic [POS_W-1:0]        rsp_found_position;

   table_request_type       pending_requests[$];
   search_result_type       expected_results[$];
   // Table as the checker sees it (updated at acceptance) and as the
   // generator plans it (updated when a write is queued).
   logic signed [KEY_W-1:0] table_image   [DEPTH];
   logic signed [KEY_W-1:0] planned_table [DEPTH];

   bit                      errors_seen       = 1'b0;
   int unsigned             requests_accepted = 0;
   int unsigned             searches_issued   = 0;
   int unsigned             results_checked   = 0;
   logic [1:0]              run_phase         = PH_RSP_BUSY;
   int unsigned             hold_left         = 0;
   bit                      hold_done         = 1'b0;
   int unsigned             quiet_cycles      = 0;

   sorted_table_binary_search #(.TABLE_DEPTH(DEPTH)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_position       (req_position),
      .req_value          (req_value),
      .req_range_low      (req_range_low),
      .req_range_high     (req_range_high),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_found_position (rsp_found_position)
   );

   always #2 clock = ~clock;

   function automatic int unsigned sender_idle_pct(logic [1:0] ph);
      case (ph)
         PH_RSP_BUSY: return 7;
         PH_REQ_BUSY: return 46;
         default:     return 0;
      endcase
   endfunction

   function automatic int unsigned receiver_idle_pct(logic [1:0] ph);
      case (ph)
         PH_RSP_BUSY: return 46;
         PH_REQ_BUSY: return 7;
         default:     return 0;
      endcase
   endfunction

   // Expected outcome of a search over the current table image. The probe
   // is floor((lo + hi) / 2); a key below entry 0 ends the search rather
   // than letting hi drop below zero.
   function automatic search_result_type search_table(logic signed [KEY_W-1:0] key,
                                                      logic [POS_W-1:0] lo_in,
                                                      logic [POS_W-1:0] hi_in);
      int                lo;
      int                hi;
      int                mid;
      logic [POS_W-1:0]  probe;
      search_result_type res;
      res = '0;
      lo  = int'(lo_in);
      hi  = int'(hi_in);
      if (hi > DEPTH - 1) hi = DEPTH - 1;   // saturate past the table
      while (lo <= hi) begin
         mid   = (lo + hi) / 2;
         probe = POS_W'(mid);
         if (key == table_image[probe]) begin
            res.found          = 1'b1;
            res.found_position = probe;
            break;
         end else if (key < table_image[probe]) begin
            if (mid == 0) break;
            hi = mid - 1;
         end else begin
            lo = mid + 1;
         end
      end
      return res;
   endfunction

   task automatic queue_write(logic [1:0] ph, logic [POS_W-1:0] pos,
                              logic signed [KEY_W-1:0] val);
      table_request_type r;
      r.phase      = ph;
      r.cmd        = CMD_WRITE;
      r.position   = pos;
      r.value      = val;
      r.range_low  = POS_W'($urandom);   // don't-care on a write
      r.range_high = POS_W'($urandom);
      pending_requests.push_back(r);
      if (pos < DEPTH) planned_table[pos] = val;
   endtask

   task automatic queue_search(logic [1:0] ph, logic signed [KEY_W-1:0] key,
                               logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
      table_request_type r;
      r.phase      = ph;
      r.cmd        = CMD_SEARCH;
      r.position   = POS_W'($urandom);   // don't-care on a search
      r.value      = key;
      r.range_low  = lo;
      r.range_high = hi;
      pending_requests.push_back(r);
   endtask

   // Request driver: when the slot is free, presents the next queued request
   // unless its phase's idle chance holds it back, and runs the predictor on
   // each accepted one. The payload is left alone while stalled.
   always @(posedge clock) begin : drive_requests
      table_request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            requests_accepted <= requests_accepted + 1;
            if (req_cmd == CMD_WRITE) begin
               if (req_position < DEPTH) table_image[req_position] = req_value;
            end else begin
               expected_results.push_back(search_table(req_value, req_range_low,
                                                       req_range_high));
               searches_issued <= searches_issued + 1;
            end
         end
         if (pending_requests.size() != 0 &&
             $urandom_range(99) >= sender_idle_pct(pending_requests[0].phase)) begin
            next_req = pending_requests.pop_front();
            req_valid      <= 1'b1;
            req_cmd        <= next_req.cmd;
            req_position   <= next_req.position;
            req_value      <= next_req.value;
            req_range_low  <= next_req.range_low;
            req_range_high <= next_req.range_high;
            run_phase      <= next_req.phase;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure. Once, early in the run, it holds off for a long
   // stretch so the request queue fills and req_stall has to rise.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && requests_accepted >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct(run_phase));
      end
   end

   // Response monitor. searches_issued moves by nonblocking assignment, so a
   // search accepted on this same edge is not yet counted here.
   always @(posedge clock) begin : check_results
      search_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_checked == searches_issued) begin
            $display("%0t: response with no search pending: found=%0b position=%0d",
                     $time, rsp_found, rsp_found_position);
            errors_seen = 1'b1;
         end else begin
            want = expected_results.pop_front();
            results_checked <= results_checked + 1;
            if (rsp_found !== want.found) begin
               $display("%0t: found expected %0b actual %0b",
                        $time, want.found, rsp_found);
               errors_seen = 1'b1;
            end
            if (rsp_found_position !== want.found_position) begin
               $display("%0t: found_position expected %0d actual %0d",
                        $time, want.found_position, rsp_found_position);
               errors_seen = 1'b1;
            end
         end
      end
   end

   // Watchdog: too long with no transfer on either channel means a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("tb: errors");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      int unsigned             made;
      int unsigned             pick;
      logic [POS_W-1:0]        idx;
      logic [1:0]              ph;
      logic [POS_W-1:0]        pos;
      logic [POS_W-1:0]        lo;
      logic [POS_W-1:0]        hi;
      logic signed [KEY_W-1:0] key;
      longint                  lower;
      longint                  upper;
      longint                  span;
      logic [63:0]             spread;
      bit                      narrow;
      int                      fresh_values[$];

      // Directed: fill every entry first, so no search ever probes an
      // unwritten entry. Entry 0 sits one above the minimum so that a key
      // below entry 0 exists; entry 15 one below the maximum.
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (i == 0)              key = KEY_MIN + 1;
         else if (i == DEPTH - 1) key = KEY_MAX - 1;
         else                     key = KEY_W'((i - 8) * 1000);
         queue_write(PH_RSP_BUSY, POS_W'(i), key);
      end
      queue_search(PH_RSP_BUSY, KEY_MIN, 4'd0, 4'd15);      // below entry 0
      queue_search(PH_RSP_BUSY, KEY_MAX, 4'd0, 4'd15);      // above every entry
      queue_search(PH_RSP_BUSY, KEY_MIN + 1, 4'd0, 4'd15);  // hit at index 0
      queue_search(PH_RSP_BUSY, KEY_MAX - 1, 4'd0, 4'd15);  // hit at the last entry
      queue_search(PH_RSP_BUSY, 32'sd3000, 4'd0, 4'd15);    // hit mid table
      queue_search(PH_RSP_BUSY, 32'sd3001, 4'd0, 4'd15);    // miss between entries
      queue_search(PH_RSP_BUSY, 32'sd0, 4'd12, 4'd4);       // empty range
      queue_search(PH_RSP_BUSY, 32'sd0, 4'd8, 4'd8);        // one-entry range
      queue_write(PH_RSP_BUSY, 4'd0, KEY_MIN);
      queue_search(PH_RSP_BUSY, KEY_MIN, 4'd0, 4'd15);
      queue_write(PH_RSP_BUSY, 4'd15, KEY_MAX);
      queue_search(PH_RSP_BUSY, KEY_MAX, 4'd15, 4'd15);

      // Random: mostly searches on a sorted table, with single writes that
      // usually keep it sorted, occasional full reloads (some narrow enough
      // to give duplicates) and some writes that break the ordering.
      made = 0;
      while (made < RANDOM_ITEMS) begin
         ph   = 2'(made * 3 / RANDOM_ITEMS);
         pick = $urandom_range(99);
         if (pick < 3) begin
            fresh_values.delete();
            narrow = ($urandom_range(3) == 0);
            for (int i = 0; i < DEPTH; i++)
               fresh_values.push_back(narrow ? int'($urandom_range(20)) - 10
                                             : int'($urandom));
            fresh_values.sort();
            for (int i = 0; i < DEPTH; i++)
               queue_write(ph, POS_W'(i), fresh_values[i]);
            made += DEPTH;
         end else if (pick < 25) begin
            pos = POS_W'($urandom);
            key = $urandom;
            if ($urandom_range(9) < 7) begin
               lower = (pos == 0) ? longint'(KEY_MIN)
                                  : longint'(planned_table[pos - 4'd1]);
               upper = (pos == DEPTH - 1) ? longint'(KEY_MAX)
                                          : longint'(planned_table[pos + 4'd1]);
               if (lower <= upper) begin
                  span   = upper - lower;
                  spread = {$urandom, $urandom};
                  key    = KEY_W'(lower + longint'(spread % (span + 1)));
               end
            end
            queue_write(ph, pos, key);
            made++;
         end else begin
            idx  = POS_W'($urandom_range(DEPTH - 1));
            pick = $urandom_range(9);
            if (pick < 5)       key = planned_table[idx];
            else if (pick < 7)  key = planned_table[idx] + ($urandom_range(1) ? 1 : -1);
            else if (pick == 7) key = $urandom_range(1) ? KEY_MIN : KEY_MAX;
            else                key = $urandom;
            pick = $urandom_range(9);
            if (pick < 3) begin
               lo = 4'd0;
               hi = 4'd15;
            end else if (pick < 8) begin
               lo = POS_W'($urandom_range(DEPTH - 1));
               hi = POS_W'($urandom_range(DEPTH - 1, lo));
            end else begin
               lo = POS_W'($urandom);  // may well be an empty range
               hi = POS_W'($urandom);
            end
            queue_search(ph, key, lo, hi);
            made++;
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Sampled on the falling edge, clear of the driver's updates.
      while (pending_requests.size() != 0 || req_valid ||
             results_checked != searches_issued)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (errors_seen || results_checked != searches_issued) begin
         $display("tb: errors");
      end else begin
         $display("tb: clean");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/stbs_pkg.sv
src/stbs_ram.sv
src/stbs_front.sv
src/stbs_queue.sv
src/stbs_back.sv
src/sorted_table_binary_search.sv
tb/sv/tb.sv
